[rtl/mlve_pkg.sv]
// Package for the mutation list varint encoder: item, result and job types,
// command codes and default sizes. No dependencies.
`default_nettype none

package mlve_pkg;

  // Width of the position fields on the ports, and the widest position the
  // design supports internally.
  localparam int unsigned FieldPosW = 31;
  localparam int unsigned PosMaxW   = 32;

  // Defaults for the top-level parameters.
  localparam int unsigned POS_WIDTH_DEF   = 31;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    CMD_MUT       = 2'd0,
    CMD_MUT_END   = 2'd1,
    CMD_RANGE     = 2'd2,
    CMD_RANGE_END = 2'd3
  } cmd_e_t;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [FieldPosW-1:0] site_pos;
    logic [FieldPosW-1:0] run_end;
    logic [3:0]           mut_code;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } result_t;

  // One unit of work for the byte serializer: an optional varint A, an
  // optional varint B, an optional literal byte C and an optional zero byte D,
  // sent in that order.
  typedef struct packed {
    logic               a_en;
    logic [PosMaxW-1:0] a_val;
    logic               b_en;
    logic [PosMaxW-1:0] b_val;
    logic               c_en;
    logic [7:0]         c_val;
    logic               d_en;
  } job_t;

endpackage

`default_nettype wire

[rtl/mlve_fifo.sv]
// Short register queue of serializer jobs between the front and back parts.
// Depends on mlve_pkg for the job type.
`default_nettype none

module mlve_fifo #(
  parameter int unsigned DEPTH = mlve_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  mlve_pkg::job_t     wr_job,
  output logic               full,
  input  wire logic          rd_en,
  output mlve_pkg::job_t     rd_job,
  output logic               empty
);
  import mlve_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full   = (count == CntW'(DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

  // The occupancy never runs past the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("queue occupancy exceeds its depth");

endmodule

`default_nettype wire

[rtl/mlve_front.sv]
// Front part: takes input items, keeps the unpaired mutation and the open
// range, and turns each item into at most one serializer job. Uses mlve_pkg.
`default_nettype none

module mlve_front #(
  parameter int unsigned POS_WIDTH = mlve_pkg::POS_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  mlve_pkg::item_t    item,
  output logic               job_push,
  output mlve_pkg::job_t     job,
  input  wire logic          job_full
);
  import mlve_pkg::*;

  logic [POS_WIDTH-1:0] held_pos;
  logic [3:0]           held_mut;
  logic                 held_valid;
  logic [POS_WIDTH-1:0] range_start;
  logic [POS_WIDTH-1:0] range_stop;
  logic                 range_valid;

  logic                 accept;
  logic [PosMaxW-1:0]   pos_ext;
  logic [PosMaxW-1:0]   stop_ext;
  logic [POS_WIDTH-1:0] pos;
  logic [POS_WIDTH-1:0] stop;
  logic                 touch;
  logic                 job_valid;

  assign full     = job_full;
  assign accept   = push && !job_full;
  assign pos_ext  = PosMaxW'(item.site_pos);
  assign stop_ext = PosMaxW'(item.run_end);
  assign pos      = pos_ext[POS_WIDTH-1:0];
  assign stop     = stop_ext[POS_WIDTH-1:0];
  assign touch    = ({1'b0, range_stop} + (POS_WIDTH + 1)'(1)) == {1'b0, pos};
  assign job_push = accept && job_valid;

  always_comb begin
    job       = '0;
    job_valid = 1'b0;
    case (cmd_e_t'(item.cmd))
      CMD_MUT: begin
        if (held_valid) begin
          job_valid = 1'b1;
          job.a_en  = 1'b1;
          job.a_val = PosMaxW'(held_pos);
          job.b_en  = 1'b1;
          job.b_val = PosMaxW'(pos);
          job.c_en  = 1'b1;
          job.c_val = {item.mut_code, held_mut};
        end
      end
      CMD_MUT_END: begin
        job_valid = 1'b1;
        job.d_en  = 1'b1;
        if (held_valid) begin
          job.a_en  = 1'b1;
          job.a_val = PosMaxW'(held_pos);
          job.c_en  = 1'b1;
          job.c_val = {4'b0000, held_mut};
        end
      end
      CMD_RANGE: begin
        if (range_valid && !touch) begin
          job_valid = 1'b1;
          job.a_en  = 1'b1;
          job.a_val = PosMaxW'(range_stop);
          job.b_en  = (range_start != range_stop);
          job.b_val = PosMaxW'(range_start);
        end
      end
      CMD_RANGE_END: begin
        job_valid = 1'b1;
        job.d_en  = 1'b1;
        if (range_valid) begin
          job.a_en  = 1'b1;
          job.a_val = PosMaxW'(range_stop);
          job.b_en  = (range_start != range_stop);
          job.b_val = PosMaxW'(range_start);
        end
      end
      default: begin
        job_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_pos    <= '0;
      held_mut    <= '0;
      held_valid  <= 1'b0;
      range_start <= '0;
      range_stop  <= '0;
      range_valid <= 1'b0;
    end else if (accept) begin
      case (cmd_e_t'(item.cmd))
        CMD_MUT: begin
          if (held_valid) begin
            held_valid <= 1'b0;
          end else begin
            held_pos   <= pos;
            held_mut   <= item.mut_code;
            held_valid <= 1'b1;
          end
        end
        CMD_MUT_END: begin
          held_valid <= 1'b0;
        end
        CMD_RANGE: begin
          if (range_valid && touch) begin
            range_stop <= stop;
          end else begin
            range_start <= pos;
            range_stop  <= stop;
            range_valid <= 1'b1;
          end
        end
        CMD_RANGE_END: begin
          range_valid <= 1'b0;
        end
        default: begin
          range_valid <= range_valid;
        end
      endcase
    end
  end

  // The second mutation of a pair always leaves nothing held.
  a_pair_clears: assert property (@(posedge clk) disable iff (rst)
    accept && (item.cmd == CMD_MUT) && held_valid |=> !held_valid)
    else $error("mutation pair did not clear the held mutation");

endmodule

`default_nettype wire

[rtl/mlve_back.sv]
// Back part: takes jobs from the queue and sends their bytes one per cycle
// through an output register unless the result side stalls. Uses mlve_pkg for job and result types.
`default_nettype none

module mlve_back #(
  parameter int unsigned POS_WIDTH = mlve_pkg::POS_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  mlve_pkg::job_t     job,
  input  wire logic          job_empty,
  output logic               job_pop,
  output logic               empty,
  input  wire logic          pop,
  output mlve_pkg::result_t  result
);
  import mlve_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_A    = 5'b00010,
    PH_B    = 5'b00100,
    PH_C    = 5'b01000,
    PH_D    = 5'b10000
  } phase_t;

  phase_t               phase;
  phase_t               phase_next;
  phase_t               follow;
  phase_t               first;
  logic [POS_WIDTH-1:0] rest;
  logic [POS_WIDTH-1:0] rest_next;
  logic                 b_en;
  logic [POS_WIDTH-1:0] b_val;
  logic                 c_en;
  logic [7:0]           c_val;
  logic                 d_en;
  logic                 rvalid;

  logic       more;
  logic [7:0] cur_byte;
  logic       seg_done;
  logic       job_last;
  logic       advance;
  logic       emit;
  logic       take;

  assign more     = |rest[POS_WIDTH-1:7];
  assign advance  = !rvalid || pop;
  assign emit     = (phase != PH_IDLE) && advance;
  assign job_last = seg_done && (follow == PH_IDLE);
  assign take     = ((phase == PH_IDLE) || (emit && job_last)) && !job_empty;
  assign job_pop  = take;
  assign empty    = !rvalid;

  // Byte for the current phase, and the phase that comes after it.
  always_comb begin
    cur_byte = 8'h00;
    seg_done = 1'b1;
    follow   = PH_IDLE;
    case (phase)
      PH_A: begin
        cur_byte = {more, rest[6:0]};
        seg_done = !more;
        follow   = b_en ? PH_B : c_en ? PH_C : d_en ? PH_D : PH_IDLE;
      end
      PH_B: begin
        cur_byte = {more, rest[6:0]};
        seg_done = !more;
        follow   = c_en ? PH_C : d_en ? PH_D : PH_IDLE;
      end
      PH_C: begin
        cur_byte = c_val;
        follow   = d_en ? PH_D : PH_IDLE;
      end
      PH_D: begin
        cur_byte = 8'h00;
        follow   = PH_IDLE;
      end
      default: begin
        cur_byte = 8'h00;
        follow   = PH_IDLE;
      end
    endcase
  end

  assign first = job.a_en ? PH_A : job.b_en ? PH_B : job.c_en ? PH_C : PH_D;

  always_comb begin
    phase_next = phase;
    rest_next  = rest;
    if (take) begin
      phase_next = first;
      rest_next  = job.a_en ? job.a_val[POS_WIDTH-1:0] : job.b_val[POS_WIDTH-1:0];
    end else if (emit) begin
      if (seg_done) begin
        phase_next = follow;
        if (follow == PH_B) begin
          rest_next = b_val;
        end
      end else begin
        rest_next = rest >> 7;
      end
    end
  end

  always_ff @(posedge clk) begin
    rest <= rest_next;
    if (take) begin
      b_en  <= job.b_en;
      b_val <= job.b_val[POS_WIDTH-1:0];
      c_en  <= job.c_en;
      c_val <= job.c_val;
      d_en  <= job.d_en;
    end
    if (emit) begin
      result <= '{out_byte: cur_byte, last_byte: job_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      rvalid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (emit) begin
        rvalid <= 1'b1;
      end else if (pop) begin
        rvalid <= 1'b0;
      end
    end
  end

  // A new job is only taken when the serializer is free or finishing a job.
  a_take_free: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> (phase == PH_IDLE) || (emit && job_last))
    else $error("job taken while another is in progress");

  // After a byte that is not a job's last, the job is still in progress.
  a_job_continues: assert property (@(posedge clk) disable iff (rst)
    emit && !job_last |=> phase != PH_IDLE)
    else $error("job dropped before its last byte");

  // A varint byte with its continuation bit set never ends a job.
  a_cont_not_last: assert property (@(posedge clk) disable iff (rst)
    emit && ((phase == PH_A) || (phase == PH_B)) && cur_byte[7] |-> !job_last)
    else $error("continuation byte marked as last");

endmodule

`default_nettype wire

[rtl/mutation_list_varint_encoder.sv]
// Top level of the mutation list varint encoder: front part, job queue and
// byte serializer. Depends on mlve_pkg, mlve_front, mlve_fifo and mlve_back.
//
//   Channel  | Handshake          | Payload   | Transfer when
//   ---------+--------------------+-----------+---------------------------
//   items    | push in, full out  | item_t    | push high and full low
//   results  | empty out, pop in  | result_t  | pop high and empty low
//
// An item causes at most 11 bytes, as for a mutation pair with two 5-byte
// varints; the serializer sends them one byte per cycle unless the result
// side stalls, and the output byte register sets that rate.
// Items that cause no bytes are handled by the front part alone. The job
// queue holds QUEUE_DEPTH jobs, so items keep being taken while the
// serializer works or the result side stalls, until the queue is full.
// Reset is synchronous; it clears the held mutation, the open range, the
// queue, the serializer phase and the output valid flag. The first item
// can be taken in the cycle after reset is released.
`default_nettype none

module mutation_list_varint_encoder #(
  parameter int unsigned POS_WIDTH   = mlve_pkg::POS_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = mlve_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  mlve_pkg::item_t    item,
  output logic               empty,
  input  wire logic          pop,
  output mlve_pkg::result_t  result
);
  import mlve_pkg::*;

  // Jobs travel from the front part to the serializer through the queue.
  job_t front_job;
  job_t back_job;
  logic front_push;
  logic queue_full;
  logic queue_empty;
  logic back_pop;

  // The front part holds the pairing and range-merge state and decides
  // which bytes each item causes.
  mlve_front #(
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .job_push (front_push),
    .job      (front_job),
    .job_full (queue_full)
  );

  // The queue lets the front part take new items while bytes of earlier
  // items are still going out.
  mlve_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (front_push),
    .wr_job (front_job),
    .full   (queue_full),
    .rd_en  (back_pop),
    .rd_job (back_job),
    .empty  (queue_empty)
  );

  // The serializer splits each job into varint groups and literal bytes and
  // marks the final byte of each job.
  mlve_back #(
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_empty (queue_empty),
    .job_pop   (back_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

[bench/tb_mutation_list_varint_encoder.sv]
// Self-checking bench for the mutation list varint encoder: drives items in,
// pops bytes out and checks each byte against an in-bench encoder model.
// Depends on mlve_pkg and the mutation_list_varint_encoder RTL.
`timescale 1ns / 1ps

// The scoreboard keeps its own copy of the encoder state: the unpaired
// mutation and the open ambiguous range. Each accepted item is turned into
// the bytes it should cause, and those bytes wait here until they pop out.
class encoded_byte_scoreboard;
  mlve_pkg::result_t want_q[$];
  logic [7:0]        burst[$];

  logic [30:0] mut_pos;
  logic [3:0]  mut_code;
  bit          mut_held;
  logic [30:0] span_lo;
  logic [30:0] span_hi;
  bit          span_open;

  int errors;
  int checked;
  int merges;
  int pairs;
  int cmd_seen[4];

  function new();
    mut_pos   = '0;
    mut_code  = '0;
    mut_held  = 1'b0;
    span_lo   = '0;
    span_hi   = '0;
    span_open = 1'b0;
    errors    = 0;
    checked   = 0;
    merges    = 0;
    pairs     = 0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
  endfunction

  // Appends one byte to the burst of the item being noted.
  function void add_byte(logic [7:0] b);
    burst.insert(burst.size(), b);
  endfunction

  // Seven bits per byte, low group first, bit 7 set while more groups follow.
  function void add_varint(logic [31:0] v);
    logic [31:0] rest;
    logic [6:0]  grp;
    rest = v;
    do begin
      grp  = rest[6:0];
      rest = rest >> 7;
      add_byte({rest != 0, grp});
    end while (rest != 0);
  endfunction

  function void add_span();
    add_varint({1'b0, span_hi});
    if (span_lo != span_hi) add_varint({1'b0, span_lo});
  endfunction

  function int pending();
    return want_q.size();
  endfunction

  function void note_item(mlve_pkg::item_t it);
    mlve_pkg::result_t r;
    burst.delete();
    cmd_seen[it.cmd]++;
    case (mlve_pkg::cmd_e_t'(it.cmd))
      mlve_pkg::CMD_MUT: begin
        if (mut_held) begin
          add_varint({1'b0, mut_pos});
          add_varint({1'b0, it.site_pos});
          add_byte({it.mut_code, mut_code});
          mut_held = 1'b0;
          pairs++;
        end else begin
          mut_pos  = it.site_pos;
          mut_code = it.mut_code;
          mut_held = 1'b1;
        end
      end
      mlve_pkg::CMD_MUT_END: begin
        if (mut_held) begin
          add_varint({1'b0, mut_pos});
          add_byte({4'h0, mut_code});
          mut_held = 1'b0;
        end
        add_byte(8'h00);
      end
      mlve_pkg::CMD_RANGE: begin
        // Touch test in 32 bits, so a stop at the top never wraps to zero.
        if (span_open && ({1'b0, span_hi} + 32'd1) == {1'b0, it.site_pos}) begin
          span_hi = it.run_end;
          merges++;
        end else begin
          if (span_open) add_span();
          span_lo   = it.site_pos;
          span_hi   = it.run_end;
          span_open = 1'b1;
        end
      end
      default: begin
        if (span_open) begin
          add_span();
          span_open = 1'b0;
        end
        add_byte(8'h00);
      end
    endcase
    foreach (burst[i]) begin
      r.out_byte  = burst[i];
      r.last_byte = (i == burst.size() - 1);
      want_q.insert(want_q.size(), r);
    end
  endfunction

  task report(string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task check_byte(mlve_pkg::result_t got);
    mlve_pkg::result_t exp;
    if (want_q.size() == 0) begin
      report($sformatf("byte %02h arrived with nothing expected", got.out_byte));
      return;
    end
    exp = want_q.pop_front();
    checked++;
    if (got.out_byte !== exp.out_byte)
      report($sformatf("out_byte %02h, expected %02h", got.out_byte, exp.out_byte));
    if (got.last_byte !== exp.last_byte)
      report($sformatf("last_byte %b, expected %b (byte %02h)",
                       got.last_byte, exp.last_byte, exp.out_byte));
  endtask
endclass

module tb_mutation_list_varint_encoder;
  import mlve_pkg::*;

  logic    clk;
  logic    rst   = 1'b1;
  logic    push  = 1'b0;
  logic    pop   = 1'b0;
  item_t   item  = '0;
  logic    full;
  logic    empty;
  result_t result;

  // While no_idle is set neither side inserts bubbles, so the serializer
  // runs back to back for a long stretch.
  bit no_idle     = 1'b0;
  int items_sent  = 0;
  bit paused_once = 1'b0;

  encoded_byte_scoreboard sb;

  mutation_list_varint_encoder u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: every byte that transfers is checked against the oldest
  // expected byte. Pop is dropped on about a quarter of the cycles, which
  // lands stalls at every point of a varint and of a multi-byte burst.
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_byte(result);
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= no_idle || ($urandom_range(99) >= 24);
    end
  end

  // One item transfer. An optional bubble comes first; push then stays high
  // until full is seen low at a rising edge, and the item is handed to the
  // scoreboard in that same step so the expected bytes are queued before any
  // of them can pop out.
  task automatic send_item(cmd_e_t c, logic [31:0] p, logic [31:0] e, logic [3:0] code);
    item_t it;
    it.cmd      = c;
    it.site_pos = p[30:0];
    it.run_end  = e[30:0];
    it.mut_code = code;
    if (!no_idle && $urandom_range(99) < 24) begin
      push <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    sb.note_item(it);
    items_sent++;
  endtask

  // Stop sending and wait until every expected byte has been popped. Always
  // waits for a clock edge first, so push is never lowered and raised again in
  // the same step.
  task automatic drain_bytes();
    push <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Positions of random magnitude, so varints of every length from one to
  // five bytes show up.
  function automatic logic [31:0] rand_pos();
    int unsigned w;
    w = $urandom_range(31, 1);
    return $urandom & ((32'd1 << w) - 32'd1);
  endfunction

  // Next position of an ascending list; starts over low near the top.
  function automatic logic [31:0] next_after(logic [31:0] p);
    logic [31:0] n;
    n = p + 32'd1 + ($urandom & ((32'd1 << $urandom_range(16, 0)) - 32'd1));
    if (n > 32'h7fff_ffff) n = $urandom_range(1000, 1);
    return n;
  endfunction

  // Nucleotide codes are one-hot in real records, but any value may come.
  function automatic logic [3:0] pick_code();
    if ($urandom_range(99) < 80) return 4'b0001 << $urandom_range(3);
    return 4'($urandom_range(15));
  endfunction

  // A well-formed mutation list: ascending positions, odd or even count,
  // usually closed by an end of mutations.
  task automatic mut_list();
    int          n;
    logic [31:0] p;
    n = $urandom_range(9, 0);
    p = rand_pos();
    repeat (n) begin
      send_item(CMD_MUT, p, $urandom, pick_code());
      p = next_after(p);
    end
    if ($urandom_range(99) < 85) send_item(CMD_MUT_END, $urandom, $urandom, 4'($urandom));
  endtask

  // A range list where many ranges touch the previous one and merge; some
  // are single positions and some are reversed.
  task automatic range_list();
    int          n;
    int          r;
    logic [31:0] lo;
    logic [31:0] hi;
    n  = $urandom_range(6, 1);
    lo = rand_pos();
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 15) hi = lo;
      else if (r < 25) hi = lo - (lo >> $urandom_range(4, 1));
      else hi = next_after(lo);
      send_item(CMD_RANGE, lo, hi, 4'($urandom));
      lo = (hi < 32'h7fff_ffff && $urandom_range(99) < 45) ? hi + 32'd1 : next_after(hi);
    end
    if ($urandom_range(99) < 85) send_item(CMD_RANGE_END, $urandom, $urandom, 4'($urandom));
  endtask

  // Mutations and ranges interleaved, then both lists closed in either order.
  task automatic mixed_list();
    int          n;
    logic [31:0] mp;
    logic [31:0] rp;
    logic [31:0] hi;
    n  = $urandom_range(12, 4);
    mp = rand_pos();
    rp = rand_pos();
    repeat (n) begin
      if ($urandom_range(1)) begin
        send_item(CMD_MUT, mp, $urandom, pick_code());
        mp = next_after(mp);
      end else begin
        hi = next_after(rp);
        send_item(CMD_RANGE, rp, hi, 4'($urandom));
        rp = (hi < 32'h7fff_ffff && $urandom_range(1)) ? hi + 32'd1 : next_after(hi);
      end
    end
    if ($urandom_range(1)) begin
      send_item(CMD_MUT_END, $urandom, $urandom, 4'($urandom));
      send_item(CMD_RANGE_END, $urandom, $urandom, 4'($urandom));
    end else begin
      send_item(CMD_RANGE_END, $urandom, $urandom, 4'($urandom));
      send_item(CMD_MUT_END, $urandom, $urandom, 4'($urandom));
    end
  endtask

  // Fully random items: any command, any bit pattern in every field.
  task automatic noise_items();
    repeat ($urandom_range(4, 1))
      send_item(cmd_e_t'($urandom_range(3)), $urandom, $urandom, 4'($urandom));
  endtask

  initial begin
    int r;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Zero and the largest position as a pair, then an odd
    // leftover flushed by end of mutations, and flushes with nothing held.
    send_item(CMD_MUT, 32'd0, $urandom, 4'h1);
    send_item(CMD_MUT, 32'h7fff_ffff, $urandom, 4'h8);
    send_item(CMD_MUT, 32'd127, $urandom, 4'h2);
    send_item(CMD_MUT_END, $urandom, $urandom, 4'($urandom));
    send_item(CMD_MUT_END, $urandom, $urandom, 4'($urandom));
    send_item(CMD_RANGE_END, $urandom, $urandom, 4'($urandom));
    // Touching ranges merge, a gap emits the held one, and a merge may leave
    // a reversed range behind.
    send_item(CMD_RANGE, 32'd128, 32'd200, 4'($urandom));
    send_item(CMD_RANGE, 32'd201, 32'd16384, 4'($urandom));
    send_item(CMD_RANGE, 32'd16386, 32'd16386, 4'($urandom));
    send_item(CMD_RANGE, 32'd16387, 32'd5, 4'($urandom));
    send_item(CMD_RANGE, 32'h7fff_fffe, 32'h7fff_ffff, 4'($urandom));
    // A stop at the top plus one must not wrap around and match start zero.
    send_item(CMD_RANGE, 32'd0, 32'd0, 4'($urandom));
    // Mutations interleaved with an open range, which then merges from zero.
    send_item(CMD_MUT, 32'd300, $urandom, 4'h4);
    send_item(CMD_RANGE, 32'd1, 32'd1, 4'($urandom));
    send_item(CMD_MUT, 32'd301, $urandom, 4'hf);
    send_item(CMD_RANGE_END, $urandom, $urandom, 4'($urandom));
    send_item(CMD_RANGE_END, $urandom, $urandom, 4'($urandom));
    send_item(CMD_MUT, 32'h7fff_ffff, $urandom, 4'h0);
    send_item(CMD_RANGE, 32'd50, 32'd10, 4'($urandom));
    send_item(CMD_MUT_END, $urandom, $urandom, 4'($urandom));
    send_item(CMD_RANGE_END, $urandom, $urandom, 4'($urandom));
    // Varint length boundaries: two bytes at the top, four at the bottom.
    send_item(CMD_MUT, 32'd16383, $urandom, 4'h4);
    send_item(CMD_MUT, 32'd2097152, $urandom, 4'h2);
    send_item(CMD_MUT_END, $urandom, $urandom, 4'($urandom));

    // Let everything from the directed part come out before random traffic.
    drain_bytes();

    // Random part, mostly well-formed lists with random content.
    while (items_sent < 445) begin
      no_idle = (items_sent >= 170 && items_sent < 290);
      if (!paused_once && items_sent >= 330) begin
        paused_once = 1'b1;
        drain_bytes();
      end
      r = $urandom_range(99);
      if (r < 30) mut_list();
      else if (r < 55) range_list();
      else if (r < 80) mixed_list();
      else noise_items();
    end
    no_idle = 1'b0;

    // Wait for the last expected byte, then a little longer so a stray
    // extra byte would still be caught.
    drain_bytes();
    repeat (40) @(posedge clk);

    $display("covered %0d items: %0d mutation, %0d end of mutations, %0d range, %0d end of ranges",
             items_sent, sb.cmd_seen[CMD_MUT], sb.cmd_seen[CMD_MUT_END],
             sb.cmd_seen[CMD_RANGE], sb.cmd_seen[CMD_RANGE_END]);
    $display("%0d bytes checked, %0d mutation pairs, %0d range merges, %0d errors",
             sb.checked, sb.pairs, sb.merges, sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run of this stimulus.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
